// ----- rtl/sorted_key_table_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_key_table_macros.svh
// Assertion macros used by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SKT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SKT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Request and status codes and the per-cell load command of the sorted key
// table.
// ----------------------------------------------------------------------------
package skt_pkg;

	// Request kinds; the unused code behaves as a lookup
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Load command for one cell of the chain
	typedef struct packed {
		logic load_new;    // take the request's key and value
		logic load_left;   // take the lower neighbor's entry (insert shift)
		logic load_right;  // take the upper neighbor's entry (delete shift)
	} cell_cmd_t;

endpackage

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to DEPTH key/value entries kept in ascending signed key order,
// serving lookup, insert and delete requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. In the cycle it is
// taken, each cell of the chain compares its key against the request key;
// in the next cycle (busy high) the flags select the position, the cells
// shift up or down one place, and the result is registered. done is high
// for exactly one cycle after that with status, index, found_value and
// count; the receiver cannot stall, so the result must be taken in that
// cycle. A new request may be started in the same cycle that done is shown.
// Table contents are undefined after reset; the entry count starts at zero.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [1:0]  kind,
	input  logic signed [31:0] key,
	input  logic        [31:0] value,
	output logic               done,
	output logic        [1:0]  status,
	output logic        [3:0]  index,
	output logic        [31:0] found_value,
	output logic        [4:0]  count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                      busy_q;
	logic               [1:0]  kind_q;
	logic signed        [31:0] key_q;
	logic               [31:0] value_q;
	logic               [CW-1:0] count_q;
	logic                      done_q;
	logic               [1:0]  status_q;
	logic               [3:0]  index_q;
	logic               [31:0] found_value_q;

	logic                      take;
	logic               [DEPTH-1:0] lt_w;
	logic               [DEPTH-1:0] eq_w;
	logic               [DEPTH-1:0] occ_w;
	logic               [DEPTH-1:0] pos_w;
	logic signed        [31:0] key_w   [DEPTH];
	logic               [31:0] value_w [DEPTH];
	skt_pkg::cell_cmd_t        cmd_w   [DEPTH];

	logic                      hit;
	logic                      full;
	logic               [3:0]  pos_idx;
	logic               [31:0] hit_value;
	logic                      do_ins;
	logic                      do_del;
	logic               [1:0]  status_d;
	logic               [3:0]  index_d;
	logic               [31:0] found_value_d;
	logic               [CW-1:0] count_d;

	assign take = start && !busy_q;

	// Chain of cells, each wired to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ_w[i] = CW'(i) < count_q;

		if (i == 0) begin : g_first
			if (DEPTH == 1) begin : g_only
				skt_cell u_cell (
					.clk(clk), .arst_n(arst_n), .cmp_en(take), .occupied(occ_w[i]),
					.want_key(key), .cmd(cmd_w[i]),
					.new_key(key_q), .new_value(value_q),
					.left_key(key_w[i]), .left_value(value_w[i]),
					.right_key(key_w[i]), .right_value(value_w[i]),
					.cell_key(key_w[i]), .cell_value(value_w[i]),
					.lt(lt_w[i]), .eq(eq_w[i])
				);
			end else begin : g_head
				skt_cell u_cell (
					.clk(clk), .arst_n(arst_n), .cmp_en(take), .occupied(occ_w[i]),
					.want_key(key), .cmd(cmd_w[i]),
					.new_key(key_q), .new_value(value_q),
					.left_key(key_w[i]), .left_value(value_w[i]),
					.right_key(key_w[i+1]), .right_value(value_w[i+1]),
					.cell_key(key_w[i]), .cell_value(value_w[i]),
					.lt(lt_w[i]), .eq(eq_w[i])
				);
			end
		end else if (i == DEPTH - 1) begin : g_last
			skt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmp_en(take), .occupied(occ_w[i]),
				.want_key(key), .cmd(cmd_w[i]),
				.new_key(key_q), .new_value(value_q),
				.left_key(key_w[i-1]), .left_value(value_w[i-1]),
				.right_key(key_w[i]), .right_value(value_w[i]),
				.cell_key(key_w[i]), .cell_value(value_w[i]),
				.lt(lt_w[i]), .eq(eq_w[i])
			);
		end else begin : g_mid
			skt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmp_en(take), .occupied(occ_w[i]),
				.want_key(key), .cmd(cmd_w[i]),
				.new_key(key_q), .new_value(value_q),
				.left_key(key_w[i-1]), .left_value(value_w[i-1]),
				.right_key(key_w[i+1]), .right_value(value_w[i+1]),
				.cell_key(key_w[i]), .cell_value(value_w[i]),
				.lt(lt_w[i]), .eq(eq_w[i])
			);
		end
	end

	// Mark the boundary cell: first cell that is empty or whose key is not below the request key
	always_comb begin
		pos_w[0] = !lt_w[0];
		for (int i = 1; i < DEPTH; i++) begin
			pos_w[i] = !lt_w[i] && lt_w[i-1];
		end
	end

	// Reduce flags to hit, position and the matching value
	always_comb begin
		hit       = |eq_w;
		pos_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos_idx   = pos_idx | (pos_w[i] ? 4'(i) : 4'd0);
			hit_value = hit_value | (eq_w[i] ? value_w[i] : 32'd0);
		end
	end

	assign full = count_q == CW'(DEPTH);

	// Decode the request into result and table action
	always_comb begin
		status_d      = skt_pkg::ST_NOT_FOUND;
		index_d       = '0;
		found_value_d = '0;
		count_d       = count_q;
		do_ins        = 1'b0;
		do_del        = 1'b0;
		unique case (kind_q)
			skt_pkg::KIND_INSERT: begin
				if (hit) begin
					status_d = skt_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_d = skt_pkg::ST_FULL;
				end else begin
					status_d = skt_pkg::ST_DONE;
					index_d  = pos_idx;
					count_d  = count_q + CW'(1);
					do_ins   = 1'b1;
				end
			end
			skt_pkg::KIND_DELETE: begin
				if (hit) begin
					status_d = skt_pkg::ST_DONE;
					index_d  = pos_idx;
					count_d  = count_q - CW'(1);
					do_del   = 1'b1;
				end
			end
			default: begin
				if (hit) begin
					status_d      = skt_pkg::ST_DONE;
					index_d       = pos_idx;
					found_value_d = hit_value;
				end
			end
		endcase
	end

	// Drive each cell's load command for the shift
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cmd_w[i].load_new   = busy_q && do_ins && pos_w[i];
			cmd_w[i].load_left  = busy_q && do_ins && !lt_w[i] && !pos_w[i];
			cmd_w[i].load_right = busy_q && do_del && !lt_w[i];
		end
	end

	// Sequence take, execute, report and update the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q;
			if (take) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q  <= 1'b0;
				count_q <= count_d;
			end
		end
	end

	// Latch request payload and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if (busy_q) begin
			status_q      <= status_d;
			index_q       <= index_d;
			found_value_q <= found_value_d;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign index       = index_q;
	assign found_value = found_value_q;
	assign count       = 5'(count_q);

	`SKT_ASSERT(a_take_sets_busy, take |=> busy_q, "request taken but busy not raised")
	`SKT_ASSERT(a_busy_one_cycle, busy_q |=> !busy_q, "execute phase lasted more than one cycle")
	`SKT_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without an execute phase")
	`SKT_ASSERT(a_unique_match, busy_q |-> $onehot0(eq_w), "more than one cell matched the key")
	`SKT_ASSERT_ALWAYS(a_count_bound, !arst_n || count_q <= CW'(DEPTH), "entry count beyond table depth")

endmodule

// ----- rtl/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell
// One entry of the sorted chain: holds a key and value, compares the held key
// against a request key and loads from the request or a neighbor.
// ----------------------------------------------------------------------------
module skt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmp_en,
	input  logic               occupied,
	input  logic signed [31:0] want_key,
	input  skt_pkg::cell_cmd_t cmd,
	input  logic signed [31:0] new_key,
	input  logic        [31:0] new_value,
	input  logic signed [31:0] left_key,
	input  logic        [31:0] left_value,
	input  logic signed [31:0] right_key,
	input  logic        [31:0] right_value,
	output logic signed [31:0] cell_key,
	output logic        [31:0] cell_value,
	output logic               lt,
	output logic               eq
);

	logic signed [31:0] key_q;
	logic        [31:0] value_q;
	logic               lt_q;
	logic               eq_q;

	// Capture compare flags when a request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmp_en) begin
			lt_q <= occupied && (key_q < want_key);
			eq_q <= occupied && (key_q == want_key);
		end
	end

	// Load the entry from the request or a neighbor
	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (cmd.load_left) begin
			key_q   <= left_key;
			value_q <= left_value;
		end else if (cmd.load_right) begin
			key_q   <= right_key;
			value_q <= right_value;
		end
	end

	assign cell_key   = key_q;
	assign cell_value = value_q;
	assign lt         = lt_q;
	assign eq         = eq_q;

endmodule
